// ===== rtl/pcol_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and stage records for the particle colour pipeline
// no dependencies; every other file refers to it by scoped names

package pcol_pkg;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_SATURATION = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIGHTNESS  = 8'd1;

  // register reset values, q0.8
  localparam logic [8:0] SAT_RESET   = 9'd205;
  localparam logic [8:0] LIGHT_RESET = 9'd154;

  // fixed-point constants
  localparam logic [8:0]  Q8_ONE      = 9'd256;
  localparam logic [11:0] HUE_FULL    = 12'd3600;
  localparam logic [11:0] HUE_SECTOR  = 12'd600;
  localparam logic [9:0]  C_SCALE     = 10'd600;
  localparam logic [8:0]  M_SCALE     = 9'd300;
  localparam logic [17:0] LM_SCALE    = 18'd153600;
  localparam logic [7:0]  CHAN_MAX    = 8'd255;
  localparam logic [19:0] ALPHA_HALF  = 20'd512;
  localparam logic [10:0] DIV5_MUL    = 11'd1639;
  localparam int unsigned DIV5_SHIFT  = 13;

  // hue sector, red-yellow through magenta-red
  typedef enum logic [2:0] {
    SEC_RY,
    SEC_YG,
    SEC_GC,
    SEC_CB,
    SEC_BM,
    SEC_MR
  } sector_t;

  // channel payloads
  typedef struct packed {
    logic [11:0] hue;
    logic [10:0] opacity;
    logic [31:0] base_color;
    logic        use_hue;
  } in_t;

  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } out_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [8:0]           value;
  } cfg_t;

  // stage records
  typedef struct packed {
    logic [23:0] rgb;
    logic        use_hue;
    logic [10:0] opacity;
    logic [7:0]  alpha_factor;
    logic [8:0]  light;
    logic [8:0]  sat;
    logic [8:0]  span;
    sector_t     sector;
    logic [9:0]  xf;
  } s1_t;

  typedef struct packed {
    logic [23:0] rgb;
    logic        use_hue;
    logic [7:0]  alpha;
    sector_t     sector;
    logic [9:0]  xf;
    logic [16:0] chroma;
    logic [25:0] lm;
  } s2_t;

  typedef struct packed {
    logic [23:0] rgb;
    logic        use_hue;
    logic [7:0]  alpha;
    sector_t     sector;
    logic [25:0] cv;
    logic [25:0] xv;
    logic [25:0] mv;
  } s3_t;

  typedef struct packed {
    logic [23:0] rgb;
    logic        use_hue;
    logic [7:0]  alpha;
    logic [11:0] yr;
    logic [11:0] yg;
    logic [11:0] yb;
  } s4_t;

endpackage

// ===== rtl/pcol_ifs.sv =====
`timescale 1ns / 1ps
// valid/ready channel interfaces for input requests, results and config writes
// depends on pcol_pkg for the payload types

interface pcol_in_if;
  logic            valid;
  logic            ready;
  pcol_pkg::in_t   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pcol_out_if;
  logic            valid;
  logic            ready;
  pcol_pkg::out_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pcol_cfg_if;
  logic            valid;
  logic            ready;
  pcol_pkg::cfg_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/pcol_front.sv =====
`timescale 1ns / 1ps
// configuration registers and first pipeline stage: clamping, hsl span, hue sector
// depends on pcol_pkg and pcol_ifs

module pcol_front (
  input  logic              clk,
  input  logic              rst,
  pcol_cfg_if.sink          cfg,
  pcol_in_if.sink           pix_in,
  output logic              s1_valid,
  output pcol_pkg::s1_t     s1_data,
  input  logic              s1_ready
);

  logic [8:0]  saturation;
  logic [8:0]  lightness;
  logic        stage_ready;

  logic [8:0]  sat_c;
  logic [8:0]  light_c;
  logic [9:0]  twol;
  logic [9:0]  dl;
  logic [9:0]  span_w;
  logic [11:0] h;
  logic [11:0] u;
  logic [9:0]  xf;
  pcol_pkg::sector_t sector;
  pcol_pkg::s1_t     s1_next;

  // configuration writes, always accepted
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      saturation <= pcol_pkg::SAT_RESET;
      lightness  <= pcol_pkg::LIGHT_RESET;
    end else if (cfg.valid) begin
      if (cfg.data.index == pcol_pkg::REG_SATURATION) begin
        saturation <= cfg.data.value;
      end else if (cfg.data.index == pcol_pkg::REG_LIGHTNESS) begin
        lightness <= cfg.data.value;
      end
    end
  end

  // clamp to 1.0 and form 256 - |2l - 256|
  always_comb begin
    sat_c   = (saturation > pcol_pkg::Q8_ONE) ? pcol_pkg::Q8_ONE : saturation;
    light_c = (lightness > pcol_pkg::Q8_ONE) ? pcol_pkg::Q8_ONE : lightness;
    twol    = {light_c, 1'b0};
    if (twol >= {1'b0, pcol_pkg::Q8_ONE}) begin
      dl = twol - {1'b0, pcol_pkg::Q8_ONE};
    end else begin
      dl = {1'b0, pcol_pkg::Q8_ONE} - twol;
    end
    span_w = {1'b0, pcol_pkg::Q8_ONE} - dl;
  end

  // hue wrap, sector and offset within the sector
  always_comb begin
    h = (pix_in.data.hue >= pcol_pkg::HUE_FULL) ? pix_in.data.hue - pcol_pkg::HUE_FULL
                                                : pix_in.data.hue;
    if (h < pcol_pkg::HUE_SECTOR) begin
      sector = pcol_pkg::SEC_RY;
      u      = h;
    end else if (h < 12'd2 * pcol_pkg::HUE_SECTOR) begin
      sector = pcol_pkg::SEC_YG;
      u      = h - pcol_pkg::HUE_SECTOR;
    end else if (h < 12'd3 * pcol_pkg::HUE_SECTOR) begin
      sector = pcol_pkg::SEC_GC;
      u      = h - 12'd2 * pcol_pkg::HUE_SECTOR;
    end else if (h < 12'd4 * pcol_pkg::HUE_SECTOR) begin
      sector = pcol_pkg::SEC_CB;
      u      = h - 12'd3 * pcol_pkg::HUE_SECTOR;
    end else if (h < 12'd5 * pcol_pkg::HUE_SECTOR) begin
      sector = pcol_pkg::SEC_BM;
      u      = h - 12'd4 * pcol_pkg::HUE_SECTOR;
    end else begin
      sector = pcol_pkg::SEC_MR;
      u      = h - 12'd5 * pcol_pkg::HUE_SECTOR;
    end
    // rising edge in even sectors, falling edge in odd ones
    case (sector) inside
      pcol_pkg::SEC_YG, pcol_pkg::SEC_CB, pcol_pkg::SEC_MR: xf = 10'(pcol_pkg::HUE_SECTOR - u);
      default:                                              xf = u[9:0];
    endcase
  end

  // stage record
  always_comb begin
    s1_next.rgb          = pix_in.data.base_color[23:0];
    s1_next.use_hue      = pix_in.data.use_hue;
    s1_next.opacity      = pix_in.data.opacity;
    s1_next.alpha_factor = pix_in.data.use_hue ? pcol_pkg::CHAN_MAX
                                               : pix_in.data.base_color[31:24];
    s1_next.light        = light_c;
    s1_next.sat          = sat_c;
    s1_next.span         = span_w[8:0];
    s1_next.sector       = sector;
    s1_next.xf           = xf;
  end

  // stage register, advances when empty or drained
  assign stage_ready  = !s1_valid || s1_ready;
  assign pix_in.ready = stage_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (stage_ready) begin
      s1_valid <= pix_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_ready && pix_in.valid) begin
      s1_data <= s1_next;
    end
  end

endmodule

// ===== rtl/pcol_mul.sv =====
`timescale 1ns / 1ps
// stages two and three: chroma and alpha products, then chroma, x and offset terms
// depends on pcol_pkg

module pcol_mul (
  input  logic              clk,
  input  logic              rst,
  input  logic              s1_valid,
  input  pcol_pkg::s1_t     s1_data,
  output logic              s1_ready,
  output logic              s3_valid,
  output pcol_pkg::s3_t     s3_data,
  input  logic              s3_ready
);

  logic          s2_valid;
  pcol_pkg::s2_t s2_data;
  logic          s2_ready;
  pcol_pkg::s2_t s2_next;
  pcol_pkg::s3_t s3_next;

  logic [17:0] chroma_w;
  logic [18:0] aprod;
  logic [19:0] around;
  logic [9:0]  ashift;
  logic [26:0] lm_w;
  logic [26:0] cv_w;
  logic [26:0] xv_w;
  logic [25:0] cm_w;

  // chroma = span * s, alpha = round(factor * opacity / 1024), l * 256 * 600
  always_comb begin
    chroma_w = s1_data.span * s1_data.sat;
    aprod    = s1_data.alpha_factor * s1_data.opacity;
    around   = {1'b0, aprod} + pcol_pkg::ALPHA_HALF;
    ashift   = around[19:10];
    lm_w     = s1_data.light * pcol_pkg::LM_SCALE;

    s2_next.rgb     = s1_data.rgb;
    s2_next.use_hue = s1_data.use_hue;
    s2_next.alpha   = (ashift > {2'b00, pcol_pkg::CHAN_MAX}) ? pcol_pkg::CHAN_MAX : ashift[7:0];
    s2_next.sector  = s1_data.sector;
    s2_next.xf      = s1_data.xf;
    s2_next.chroma  = chroma_w[16:0];
    s2_next.lm      = lm_w[25:0];
  end

  assign s1_ready = !s2_valid || s2_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && s1_valid) begin
      s2_data <= s2_next;
    end
  end

  // full-sector value, edge value and lightness offset m
  always_comb begin
    cv_w = s2_data.chroma * pcol_pkg::C_SCALE;
    xv_w = s2_data.chroma * s2_data.xf;
    cm_w = s2_data.chroma * pcol_pkg::M_SCALE;

    s3_next.rgb     = s2_data.rgb;
    s3_next.use_hue = s2_data.use_hue;
    s3_next.alpha   = s2_data.alpha;
    s3_next.sector  = s2_data.sector;
    s3_next.cv      = cv_w[25:0];
    s3_next.xv      = xv_w[25:0];
    s3_next.mv      = s2_data.lm - cm_w;
  end

  assign s2_ready = !s3_valid || s3_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s2_ready) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s2_valid) begin
      s3_data <= s3_next;
    end
  end

endmodule

// ===== rtl/pcol_chan.sv =====
`timescale 1ns / 1ps
// stages four and five: channel select and scaling to 0..255, output register
// depends on pcol_pkg and pcol_ifs

module pcol_chan (
  input  logic              clk,
  input  logic              rst,
  input  logic              s3_valid,
  input  pcol_pkg::s3_t     s3_data,
  output logic              s3_ready,
  pcol_out_if.source        pix_out
);

  logic          s4_valid;
  pcol_pkg::s4_t s4_data;
  logic          s4_ready;
  pcol_pkg::s4_t s4_next;
  pcol_pkg::out_t out_next;

  logic [25:0] vr;
  logic [25:0] vg;
  logic [25:0] vb;

  // (v + m) * 17 >> 19, first half of the divide by 65536 * 600 / 255
  function automatic logic [11:0] scale17(input logic [25:0] v, input logic [25:0] m);
    logic [26:0] sum;
    logic [30:0] t17;
    sum = {1'b0, v} + {1'b0, m};
    t17 = {sum, 4'b0000} + {4'b0000, sum};
    return t17[30:19];
  endfunction

  // floor(y / 5) by reciprocal, then saturate
  function automatic logic [7:0] div5_sat(input logic [11:0] y);
    logic [22:0] p;
    logic [9:0]  q;
    p = y * pcol_pkg::DIV5_MUL;
    q = p[22:pcol_pkg::DIV5_SHIFT];
    return (q > {2'b00, pcol_pkg::CHAN_MAX}) ? pcol_pkg::CHAN_MAX : q[7:0];
  endfunction

  // channel values per sector
  always_comb begin
    case (s3_data.sector) inside
      pcol_pkg::SEC_RY, pcol_pkg::SEC_MR: vr = s3_data.cv;
      pcol_pkg::SEC_YG, pcol_pkg::SEC_BM: vr = s3_data.xv;
      default:                            vr = '0;
    endcase
    case (s3_data.sector) inside
      pcol_pkg::SEC_YG, pcol_pkg::SEC_GC: vg = s3_data.cv;
      pcol_pkg::SEC_RY, pcol_pkg::SEC_CB: vg = s3_data.xv;
      default:                            vg = '0;
    endcase
    case (s3_data.sector) inside
      pcol_pkg::SEC_CB, pcol_pkg::SEC_BM: vb = s3_data.cv;
      pcol_pkg::SEC_GC, pcol_pkg::SEC_MR: vb = s3_data.xv;
      default:                            vb = '0;
    endcase

    s4_next.rgb     = s3_data.rgb;
    s4_next.use_hue = s3_data.use_hue;
    s4_next.alpha   = s3_data.alpha;
    s4_next.yr      = scale17(vr, s3_data.mv);
    s4_next.yg      = scale17(vg, s3_data.mv);
    s4_next.yb      = scale17(vb, s3_data.mv);
  end

  assign s3_ready = !s4_valid || s4_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (s3_ready) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready && s3_valid) begin
      s4_data <= s4_next;
    end
  end

  // final scaling or base colour pass-through
  always_comb begin
    out_next.alpha = s4_data.alpha;
    if (s4_data.use_hue) begin
      out_next.red   = div5_sat(s4_data.yr);
      out_next.green = div5_sat(s4_data.yg);
      out_next.blue  = div5_sat(s4_data.yb);
    end else begin
      out_next.red   = s4_data.rgb[23:16];
      out_next.green = s4_data.rgb[15:8];
      out_next.blue  = s4_data.rgb[7:0];
    end
  end

  // output register
  assign s4_ready = !pix_out.valid || pix_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_out.valid <= 1'b0;
    end else if (s4_ready) begin
      pix_out.valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s4_ready && s4_valid) begin
      pix_out.data <= out_next;
    end
  end

endmodule

// ===== rtl/particle_color_hsl_or_argb_top.sv =====
`timescale 1ns / 1ps
// Particle colour generator: each request (hue, opacity, base ARGB word, mode bit)
// gives one ARGB result. In hue mode the colour is the six-sector HSL conversion
// with the saturation and lightness registers (indexes 0 and 1, Q0.8, reset 205
// and 154) and alpha is round(opacity * 255); in base mode red, green and blue
// pass through and alpha is round(base alpha * opacity); either alpha saturates at 255.
// One request is taken every clock while the output is not stalled; a result passes
// through the five register stages in order (front decode, loaded on the edge that
// takes its request, two multiply stages, channel scaling, output register).
// Each stage holds its item while the next one is full, so back-pressure stalls
// without loss and bubbles close up.
// Configuration writes are always accepted and take effect on the next request.
// depends on pcol_pkg, pcol_ifs, pcol_front, pcol_mul and pcol_chan

module particle_color_hsl_or_argb_top (
  input  logic        clk,
  input  logic        rst,
  pcol_cfg_if.sink    cfg,
  pcol_in_if.sink     pix_in,
  pcol_out_if.source  pix_out
);

  logic          s1_valid;
  pcol_pkg::s1_t s1_data;
  logic          s1_ready;
  logic          s3_valid;
  pcol_pkg::s3_t s3_data;
  logic          s3_ready;

  // register file, clamping and hue sector
  pcol_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .pix_in   (pix_in),
    .s1_valid (s1_valid),
    .s1_data  (s1_data),
    .s1_ready (s1_ready)
  );

  // chroma, alpha and per-sector terms
  pcol_mul u_mul (
    .clk      (clk),
    .rst      (rst),
    .s1_valid (s1_valid),
    .s1_data  (s1_data),
    .s1_ready (s1_ready),
    .s3_valid (s3_valid),
    .s3_data  (s3_data),
    .s3_ready (s3_ready)
  );

  // channel scaling and output
  pcol_chan u_chan (
    .clk      (clk),
    .rst      (rst),
    .s3_valid (s3_valid),
    .s3_data  (s3_data),
    .s3_ready (s3_ready),
    .pix_out  (pix_out)
  );

endmodule
